FILE: hw/rtl/gbe_pkg.sv
// gbe_pkg: shared constants for the grid bilinear elevation unit
// field widths, register index codes, item mode codes and default sizes
// no dependencies
package gbe_pkg;

    localparam int COORD_W  = 32;
    localparam int ELEV_W   = 25;
    localparam int CELL_W   = 9;
    localparam int USED_W   = 10;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int Q_SHIFT  = 24;
    localparam int PROD_W   = 64;

    localparam int DEF_MAX_COLUMNS   = 512;
    localparam int DEF_MAX_ROWS      = 512;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int NUM_BANKS  = 4;
    localparam int BANK_SEL_W = 2;

    localparam int OUT_DEPTH = 16;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_USED  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED     = 3'd5;

endpackage

FILE: hw/rtl/grid_bilinear_elevation_unit.sv
// grid_bilinear_elevation_unit: stored elevation grid with bilinear queries
// grid held in four parity banks, a staged pipeline and an output queue
// depends on gbe_pkg
//
// channel   direction  handshake                   payload
// item      in         item_valid / item_stall     mode, query_x, query_y, cell_*
// result    out        result_valid / result_stall elevation_out
// config    in         cfg_write                   cfg_index, cfg_data
//
// one item per cycle unless stalled; query results are queued after stage 8
// the four parity banks each give one read per cycle, so a query fetches all
// four neighbor cells at once; write items take no result slot
// async reset clears control; grid contents are undefined until written
// results wait in a 16-entry queue; items stall only with 16 queries outstanding
module grid_bilinear_elevation_unit #(
    parameter int MAX_COLUMNS   = gbe_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS      = gbe_pkg::DEF_MAX_ROWS,
    parameter int FRACTION_BITS = gbe_pkg::DEF_FRACTION_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [gbe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gbe_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                mode,
    input  logic signed [gbe_pkg::COORD_W-1:0]  query_x,
    input  logic signed [gbe_pkg::COORD_W-1:0]  query_y,
    input  logic [gbe_pkg::CELL_W-1:0]          cell_row,
    input  logic [gbe_pkg::CELL_W-1:0]          cell_col,
    input  logic signed [gbe_pkg::ELEV_W-1:0]   cell_elevation,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [gbe_pkg::ELEV_W-1:0]   elevation_out
);
    import gbe_pkg::*;

    localparam int CBW = $clog2(MAX_COLUMNS);
    localparam int RBW = $clog2(MAX_ROWS);
    localparam int NCW = $clog2(MAX_COLUMNS + 1);
    localparam int NRW = $clog2(MAX_ROWS + 1);
    localparam int UXW = NCW + Q_SHIFT;
    localparam int UYW = NRW + Q_SHIFT;
    localparam int DW  = COORD_W + 1;
    localparam int MW  = DW + COORD_W;
    localparam int WW  = FRACTION_BITS + 1;
    localparam int PW  = ELEV_W + WW;
    localparam int TW  = ELEV_W + FRACTION_BITS;
    localparam int LW  = FRACTION_BITS + WW;
    localparam int AW  = TW + 1;
    localparam int HALF_COLS  = (MAX_COLUMNS + 1) / 2;
    localparam int HALF_ROWS  = (MAX_ROWS + 1) / 2;
    localparam int BANK_DEPTH = HALF_COLS * HALF_ROWS;
    localparam int ADW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam logic [WW-1:0] ONE_W = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [LW-1:0] HALF_SS = {2'b01, {(LW - 2){1'b0}}};

    function automatic logic [ADW-1:0] bank_addr(input logic [31:0] hr, input logic [31:0] hc);
        logic [31:0] lin;
        lin = hr * HALF_COLS + hc;
        return lin[ADW-1:0];
    endfunction

    // configuration
    logic signed [COORD_W-1:0] origin_x_reg, origin_y_reg;
    logic signed [COORD_W-1:0] inv_spacing_x_reg, inv_spacing_y_reg;
    logic [USED_W-1:0]         columns_used_reg, rows_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            inv_spacing_x_reg <= '0;
            inv_spacing_y_reg <= '0;
            columns_used_reg  <= USED_W'(2);
            rows_used_reg     <= USED_W'(2);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ORIGIN_X:      origin_x_reg      <= cfg_data;
                CFG_ORIGIN_Y:      origin_y_reg      <= cfg_data;
                CFG_INV_SPACING_X: inv_spacing_x_reg <= cfg_data;
                CFG_INV_SPACING_Y: inv_spacing_y_reg <= cfg_data;
                CFG_COLUMNS_USED:  columns_used_reg  <= cfg_data[USED_W-1:0];
                CFG_ROWS_USED:     rows_used_reg     <= cfg_data[USED_W-1:0];
                default: ;
            endcase
        end
    end

    // used size clamped to the storage, edge limits
    logic [NCW-1:0] nc_x;
    logic [NRW-1:0] nr_y;
    logic [UXW-1:0] hi_x_reg;
    logic [UYW-1:0] hi_y_reg;
    logic [NCW-1:0] cap_x_reg;
    logic [NRW-1:0] cap_y_reg;

    always_comb
    begin
        if (32'(columns_used_reg) < 32'd2)
            nc_x = NCW'(2);
        else if (32'(columns_used_reg) > MAX_COLUMNS)
            nc_x = NCW'(MAX_COLUMNS);
        else
            nc_x = NCW'(columns_used_reg);
        if (32'(rows_used_reg) < 32'd2)
            nr_y = NRW'(2);
        else if (32'(rows_used_reg) > MAX_ROWS)
            nr_y = NRW'(MAX_ROWS);
        else
            nr_y = NRW'(rows_used_reg);
    end

    always_ff @(posedge clk)
    begin
        hi_x_reg  <= {nc_x - NCW'(1), {Q_SHIFT{1'b0}}};
        hi_y_reg  <= {nr_y - NRW'(1), {Q_SHIFT{1'b0}}};
        cap_x_reg <= nc_x - NCW'(2);
        cap_y_reg <= nr_y - NRW'(2);
    end

    // output queue and outstanding count
    logic [ELEV_W-1:0] fifo_mem [OUT_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  fifo_cnt_reg, fifo_cnt_next;
    logic [CNT_W-1:0]  pend_reg, pend_next;
    logic              item_take, query_take, pop, push;
    logic [ELEV_W-1:0] push_data;

    assign item_stall   = (pend_reg == CNT_W'(OUT_DEPTH));
    assign item_take    = item_valid && !item_stall;
    assign query_take   = item_take && (mode == MODE_QUERY);
    assign result_valid = (fifo_cnt_reg != '0);
    assign pop          = result_valid && !result_stall;
    assign elevation_out = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        pend_next = pend_reg;
        if (query_take && !pop)
            pend_next = pend_reg + CNT_W'(1);
        else if (!query_take && pop)
            pend_next = pend_reg - CNT_W'(1);
        fifo_cnt_next = fifo_cnt_reg;
        if (push && !pop)
            fifo_cnt_next = fifo_cnt_reg + CNT_W'(1);
        else if (!push && pop)
            fifo_cnt_next = fifo_cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= '0;
            fifo_cnt_reg <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
        end
        else
        begin
            pend_reg     <= pend_next;
            fifo_cnt_reg <= fifo_cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= push_data;
    end

    // pipeline valid bits
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic s1_mode_reg, s2_mode_reg, s3_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= item_take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg && (s3_mode_reg == MODE_QUERY);
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
        end
    end

    // stage 1: offsets from origin
    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg;
    logic [CELL_W-1:0]    s1_row_reg, s1_col_reg, s2_row_reg, s2_col_reg;
    logic [CELL_W-1:0]    s3_row_reg, s3_col_reg;
    logic [ELEV_W-1:0]    s1_elev_reg, s2_elev_reg, s3_elev_reg;

    always_ff @(posedge clk)
    begin
        s1_mode_reg <= mode;
        s1_dx_reg   <= {query_x[COORD_W-1], query_x} - {origin_x_reg[COORD_W-1], origin_x_reg};
        s1_dy_reg   <= {query_y[COORD_W-1], query_y} - {origin_y_reg[COORD_W-1], origin_y_reg};
        s1_row_reg  <= cell_row;
        s1_col_reg  <= cell_col;
        s1_elev_reg <= cell_elevation;
    end

    // stage 2: fractional index in q.24
    logic signed [MW-1:0]     prod_x, prod_y;
    logic signed [PROD_W-1:0] s2_fx_reg, s2_fy_reg;

    assign prod_x = s1_dx_reg * inv_spacing_x_reg;
    assign prod_y = s1_dy_reg * inv_spacing_y_reg;

    always_ff @(posedge clk)
    begin
        s2_mode_reg <= s1_mode_reg;
        s2_fx_reg   <= prod_x[PROD_W-1:0];
        s2_fy_reg   <= prod_y[PROD_W-1:0];
        s2_row_reg  <= s1_row_reg;
        s2_col_reg  <= s1_col_reg;
        s2_elev_reg <= s1_elev_reg;
    end

    // stage 3: clamp, lower cell and weight
    logic signed [PROD_W-1:0] hi_x_ext, hi_y_ext;
    logic [UXW-1:0] ux, rem_x;
    logic [UYW-1:0] uy, rem_y;
    logic [NCW-1:0] bx;
    logic [NRW-1:0] by;
    logic [CBW-1:0] s3_c0_reg;
    logic [RBW-1:0] s3_r0_reg;
    logic [WW-1:0]  s3_tc_reg, s3_tr_reg;

    assign hi_x_ext = {{(PROD_W - UXW){1'b0}}, hi_x_reg};
    assign hi_y_ext = {{(PROD_W - UYW){1'b0}}, hi_y_reg};

    always_comb
    begin
        if (s2_fx_reg < 0)
            ux = '0;
        else if (s2_fx_reg > hi_x_ext)
            ux = hi_x_reg;
        else
            ux = s2_fx_reg[UXW-1:0];
        bx = ux[UXW-1:Q_SHIFT];
        if (bx > cap_x_reg)
            bx = cap_x_reg;
        rem_x = ux - {bx, {Q_SHIFT{1'b0}}};

        if (s2_fy_reg < 0)
            uy = '0;
        else if (s2_fy_reg > hi_y_ext)
            uy = hi_y_reg;
        else
            uy = s2_fy_reg[UYW-1:0];
        by = uy[UYW-1:Q_SHIFT];
        if (by > cap_y_reg)
            by = cap_y_reg;
        rem_y = uy - {by, {Q_SHIFT{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        s3_mode_reg <= s2_mode_reg;
        s3_c0_reg   <= bx[CBW-1:0];
        s3_r0_reg   <= by[RBW-1:0];
        s3_tc_reg   <= rem_x[Q_SHIFT -: WW];
        s3_tr_reg   <= rem_y[Q_SHIFT -: WW];
        s3_row_reg  <= s2_row_reg;
        s3_col_reg  <= s2_col_reg;
        s3_elev_reg <= s2_elev_reg;
    end

    // grid banks by row and column parity
    logic [ADW-1:0]        rd_addr [NUM_BANKS];
    logic [ADW-1:0]        wr_addr;
    logic [BANK_SEL_W-1:0] wr_bank;
    logic                  wr_en;
    logic [ELEV_W-1:0]     bank_rd_reg [NUM_BANKS];

    always_comb
    begin
        logic [CBW-1:0] col_sel;
        logic [RBW-1:0] row_sel;
        for (int g = 0; g < NUM_BANKS; g++)
        begin
            col_sel = (s3_c0_reg[0] == g[0]) ? s3_c0_reg : s3_c0_reg + CBW'(1);
            row_sel = (s3_r0_reg[0] == g[1]) ? s3_r0_reg : s3_r0_reg + RBW'(1);
            rd_addr[g] = bank_addr(32'(row_sel >> 1), 32'(col_sel >> 1));
        end
    end

    assign wr_en = s3_valid_reg && (s3_mode_reg == MODE_WRITE)
                   && (32'(s3_row_reg) < MAX_ROWS) && (32'(s3_col_reg) < MAX_COLUMNS);
    assign wr_bank = {s3_row_reg[0], s3_col_reg[0]};
    assign wr_addr = bank_addr(32'(s3_row_reg >> 1), 32'(s3_col_reg >> 1));

    for (genvar g = 0; g < NUM_BANKS; g++)
    begin : g_bank
        logic [ELEV_W-1:0] bank_mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == BANK_SEL_W'(g)))
                bank_mem[wr_addr] <= s3_elev_reg;
            bank_rd_reg[g] <= bank_mem[rd_addr[g]];
        end
    end

    // stage 4: read data out of the banks
    logic          s4_c0p_reg, s4_r0p_reg;
    logic [WW-1:0] s4_tc_reg, s4_tr_reg;

    always_ff @(posedge clk)
    begin
        s4_c0p_reg <= s3_c0_reg[0];
        s4_r0p_reg <= s3_r0_reg[0];
        s4_tc_reg  <= s3_tc_reg;
        s4_tr_reg  <= s3_tr_reg;
    end

    // stage 5: column blend products on biased cells
    logic [ELEV_W-1:0] e00, e01, e10, e11, b00, b01, b10, b11;
    logic [WW-1:0]     wc0;
    logic [PW-1:0]     s5_pt0_reg, s5_pt1_reg, s5_pb0_reg, s5_pb1_reg;
    logic [WW-1:0]     s5_tr_reg;

    assign e00 = bank_rd_reg[{s4_r0p_reg, s4_c0p_reg}];
    assign e01 = bank_rd_reg[{s4_r0p_reg, ~s4_c0p_reg}];
    assign e10 = bank_rd_reg[{~s4_r0p_reg, s4_c0p_reg}];
    assign e11 = bank_rd_reg[{~s4_r0p_reg, ~s4_c0p_reg}];
    assign b00 = {~e00[ELEV_W-1], e00[ELEV_W-2:0]};
    assign b01 = {~e01[ELEV_W-1], e01[ELEV_W-2:0]};
    assign b10 = {~e10[ELEV_W-1], e10[ELEV_W-2:0]};
    assign b11 = {~e11[ELEV_W-1], e11[ELEV_W-2:0]};
    assign wc0 = ONE_W - s4_tc_reg;

    always_ff @(posedge clk)
    begin
        s5_pt0_reg <= b00 * wc0;
        s5_pt1_reg <= b01 * s4_tc_reg;
        s5_pb0_reg <= b10 * wc0;
        s5_pb1_reg <= b11 * s4_tc_reg;
        s5_tr_reg  <= s4_tr_reg;
    end

    // stage 6: column blend sums
    logic [PW-1:0] sum_top, sum_bot;
    logic [TW-1:0] s6_top_reg, s6_bot_reg;
    logic [WW-1:0] s6_tr_reg;

    assign sum_top = s5_pt0_reg + s5_pt1_reg;
    assign sum_bot = s5_pb0_reg + s5_pb1_reg;

    always_ff @(posedge clk)
    begin
        s6_top_reg <= sum_top[TW-1:0];
        s6_bot_reg <= sum_bot[TW-1:0];
        s6_tr_reg  <= s5_tr_reg;
    end

    // stage 7: row blend products, integer and fraction parts apart
    logic [ELEV_W-1:0]        th, bh;
    logic [FRACTION_BITS-1:0] tl, bl;
    logic [WW-1:0]            wr0;
    logic [PW-1:0]            s7_ah0_reg, s7_ah1_reg;
    logic [LW-1:0]            s7_bl0_reg, s7_bl1_reg;

    assign th  = s6_top_reg[TW-1:FRACTION_BITS];
    assign bh  = s6_bot_reg[TW-1:FRACTION_BITS];
    assign tl  = s6_top_reg[FRACTION_BITS-1:0];
    assign bl  = s6_bot_reg[FRACTION_BITS-1:0];
    assign wr0 = ONE_W - s6_tr_reg;

    always_ff @(posedge clk)
    begin
        s7_ah0_reg <= th * wr0;
        s7_ah1_reg <= bh * s6_tr_reg;
        s7_bl0_reg <= tl * wr0;
        s7_bl1_reg <= bl * s6_tr_reg;
    end

    // stage 8: row blend sums with rounding half
    logic [PW-1:0]            sum_a;
    logic [LW-1:0]            sum_b;
    logic [TW-1:0]            s8_a_reg;
    logic [FRACTION_BITS:0]   s8_q_reg;
    logic [AW-1:0]            res_sum;
    logic [ELEV_W-1:0]        res_biased;

    assign sum_a = s7_ah0_reg + s7_ah1_reg;
    assign sum_b = s7_bl0_reg + s7_bl1_reg + HALF_SS;

    always_ff @(posedge clk)
    begin
        s8_a_reg <= sum_a[TW-1:0];
        s8_q_reg <= sum_b[LW-1:FRACTION_BITS];
    end

    assign res_sum    = AW'(s8_a_reg) + AW'(s8_q_reg);
    assign res_biased = res_sum[FRACTION_BITS +: ELEV_W];
    assign push       = s8_valid_reg;
    assign push_data  = {~res_biased[ELEV_W-1], res_biased[ELEV_W-2:0]};

endmodule

FILE: hw/rtl/gbe_checker.sv
// gbe_checker: port-level checks for the grid bilinear elevation unit
// bound to grid_bilinear_elevation_unit; depends on gbe_pkg
module gbe_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                item_valid,
    input logic                                item_stall,
    input logic                                mode,
    input logic                                result_valid,
    input logic                                result_stall,
    input logic signed [gbe_pkg::ELEV_W-1:0]   elevation_out
);
    import gbe_pkg::*;

    // result held until transfer
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(elevation_out))
        else $error("stalled result changed");

    // a full item side means finished results are waiting
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("items stalled with no result waiting");

    // stall only comes up after a query transfer
    a_stall_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_stall) |-> $past(item_valid && (mode == MODE_QUERY)))
        else $error("item stall raised without a query transfer");

endmodule

bind grid_bilinear_elevation_unit gbe_checker u_gbe_checker (.*);

FILE: test/grid_elevation_checker.sv
`timescale 1ns / 100ps
// grid_elevation_checker: watches the config, item and result ports of the
// grid bilinear elevation unit, predicts each query's elevation and compares
// depends on gbe_pkg
module grid_elevation_checker #(
    parameter int MAX_COLUMNS   = gbe_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS      = gbe_pkg::DEF_MAX_ROWS,
    parameter int FRACTION_BITS = gbe_pkg::DEF_FRACTION_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [gbe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gbe_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                item_valid,
    input  logic                                item_stall,
    input  logic                                mode,
    input  logic signed [gbe_pkg::COORD_W-1:0]  query_x,
    input  logic signed [gbe_pkg::COORD_W-1:0]  query_y,
    input  logic [gbe_pkg::CELL_W-1:0]          cell_row,
    input  logic [gbe_pkg::CELL_W-1:0]          cell_col,
    input  logic signed [gbe_pkg::ELEV_W-1:0]   cell_elevation,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  logic signed [gbe_pkg::ELEV_W-1:0]   elevation_out,
    output int                                  failures,
    output int                                  outstanding
);

    import gbe_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        logic signed [ELEV_W-1:0]  elev;
    } elev_expect_t;

    elev_expect_t              elev_expected[$];
    logic signed [ELEV_W-1:0]  elev_grid [0:MAX_ROWS*MAX_COLUMNS-1];
    logic signed [COORD_W-1:0] org_x;
    logic signed [COORD_W-1:0] org_y;
    logic signed [COORD_W-1:0] inv_x;
    logic signed [COORD_W-1:0] inv_y;
    logic [USED_W-1:0]         cols_used;
    logic [USED_W-1:0]         rows_used;

    function automatic int used_span(input logic [USED_W-1:0] n, input int maxn);
        if (n < 2)
            return 2;
        if (n > maxn)
            return maxn;
        return int'(n);
    endfunction

    // lower cell and weight along one axis, index clamped to the used grid
    function automatic void grid_locate(input logic signed [COORD_W-1:0] pos,
                                        input logic signed [COORD_W-1:0] org,
                                        input logic signed [COORD_W-1:0] inv,
                                        input int used, output int base,
                                        output logic [63:0] frac);
        longint f;
        longint hi;
        longint b;
        f  = (longint'(pos) - longint'(org)) * longint'(inv);
        hi = longint'(used - 1) <<< Q_SHIFT;
        if (f < 0)
            f = 0;
        if (f > hi)
            f = hi;
        b = f >>> Q_SHIFT;
        if (b > used - 2)
            b = used - 2;
        base = int'(b);
        frac = 64'(f - (b <<< Q_SHIFT)) >> (Q_SHIFT - FRACTION_BITS);
    endfunction

    function automatic logic [63:0] biased_elev(input int r, input int c);
        return 64'(longint'(elev_grid[r * MAX_COLUMNS + c]) + (longint'(1) <<< (ELEV_W - 1)));
    endfunction

    function automatic logic signed [ELEV_W-1:0] interp_elevation(
        input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y);
        int          c0;
        int          r0;
        logic [63:0] s;
        logic [63:0] tc;
        logic [63:0] tr;
        logic [63:0] top_sum;
        logic [63:0] bot_sum;
        logic [63:0] hi_part;
        logic [63:0] lo_part;
        logic [63:0] res;
        s = 64'd1 << FRACTION_BITS;
        grid_locate(x, org_x, inv_x, used_span(cols_used, MAX_COLUMNS), c0, tc);
        grid_locate(y, org_y, inv_y, used_span(rows_used, MAX_ROWS), r0, tr);
        top_sum = biased_elev(r0, c0) * (s - tc) + biased_elev(r0, c0 + 1) * tc;
        bot_sum = biased_elev(r0 + 1, c0) * (s - tc) + biased_elev(r0 + 1, c0 + 1) * tc;
        hi_part = (top_sum >> FRACTION_BITS) * (s - tr) + (bot_sum >> FRACTION_BITS) * tr;
        lo_part = (top_sum & (s - 1)) * (s - tr) + (bot_sum & (s - 1)) * tr + ((s * s) >> 1);
        res = (hi_part + (lo_part >> FRACTION_BITS)) >> FRACTION_BITS;
        return ELEV_W'(res - (64'd1 << (ELEV_W - 1)));
    endfunction

    initial
    begin
        failures    = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        elev_expect_t head;
        elev_expect_t fresh;
        if (!rst_n)
        begin
            org_x     = '0;
            org_y     = '0;
            inv_x     = '0;
            inv_y     = '0;
            cols_used = USED_W'(2);
            rows_used = USED_W'(2);
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ORIGIN_X:      org_x = cfg_data;
                    CFG_ORIGIN_Y:      org_y = cfg_data;
                    CFG_INV_SPACING_X: inv_x = cfg_data;
                    CFG_INV_SPACING_Y: inv_y = cfg_data;
                    CFG_COLUMNS_USED:  cols_used = cfg_data[USED_W-1:0];
                    CFG_ROWS_USED:     rows_used = cfg_data[USED_W-1:0];
                    default: ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (elev_expected.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("unexpected result transfer: elevation %0d", elevation_out);
                end
                else
                begin
                    head = elev_expected.pop_front();
                    if (elevation_out !== head.elev)
                    begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display("elevation mismatch at x=%0d y=%0d: expected %0d, got %0d",
                                     head.qx, head.qy, head.elev, elevation_out);
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                if (mode == MODE_QUERY)
                begin
                    fresh.qx   = query_x;
                    fresh.qy   = query_y;
                    fresh.elev = interp_elevation(query_x, query_y);
                    elev_expected.push_back(fresh);
                end
                else if (cell_row < MAX_ROWS && cell_col < MAX_COLUMNS)
                begin
                    elev_grid[int'(cell_row) * MAX_COLUMNS + int'(cell_col)] = cell_elevation;
                end
            end
            outstanding = elev_expected.size();
        end
    end

endmodule

FILE: test/tb_grid_bilinear_elevation_unit.sv
`timescale 1ns / 100ps
// tb_grid_bilinear_elevation_unit: stimulus and verdict for the grid bilinear
// elevation unit; checking is done by grid_elevation_checker
// depends on gbe_pkg, grid_bilinear_elevation_unit and grid_elevation_checker
module tb_grid_bilinear_elevation_unit;

    import gbe_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 12;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 75;
    localparam int HOLD_PHASE  = 6;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       item_valid;
    logic                       item_stall;
    logic                       mode;
    logic signed [COORD_W-1:0]  query_x;
    logic signed [COORD_W-1:0]  query_y;
    logic [CELL_W-1:0]          cell_row;
    logic [CELL_W-1:0]          cell_col;
    logic signed [ELEV_W-1:0]   cell_elevation;
    logic                       result_valid;
    logic                       result_stall;
    logic signed [ELEV_W-1:0]   elevation_out;
    int                         failures;
    int                         outstanding;

    // stimulus-side view of the settings, used to aim queries at written cells
    logic signed [COORD_W-1:0]  org_x = '0;
    logic signed [COORD_W-1:0]  org_y = '0;
    logic signed [COORD_W-1:0]  inv_x = '0;
    logic signed [COORD_W-1:0]  inv_y = '0;
    logic [USED_W-1:0]          cols_used = USED_W'(2);
    logic [USED_W-1:0]          rows_used = USED_W'(2);
    bit                         cell_written [0:DEF_MAX_ROWS*DEF_MAX_COLUMNS-1];
    bit                         tx_steady;
    bit                         rx_steady;
    bit                         hold_off;
    int                         items_sent;

    grid_bilinear_elevation_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .mode           (mode),
        .query_x        (query_x),
        .query_y        (query_y),
        .cell_row       (cell_row),
        .cell_col       (cell_col),
        .cell_elevation (cell_elevation),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .elevation_out  (elevation_out)
    );

    grid_elevation_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .mode           (mode),
        .query_x        (query_x),
        .query_y        (query_y),
        .cell_row       (cell_row),
        .cell_col       (cell_col),
        .cell_elevation (cell_elevation),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .elevation_out  (elevation_out),
        .failures       (failures),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int used_cells(input logic [USED_W-1:0] n, input int maxn);
        if (n < 2)
            return 2;
        if (n > maxn)
            return maxn;
        return int'(n);
    endfunction

    // lower row or column that a query lands on
    function automatic int cell_base(input logic signed [COORD_W-1:0] pos,
                                     input logic signed [COORD_W-1:0] org,
                                     input logic signed [COORD_W-1:0] inv,
                                     input logic [USED_W-1:0] used_raw);
        int     used;
        longint f;
        longint b;
        used = used_cells(used_raw, DEF_MAX_COLUMNS);
        f = (longint'(pos) - longint'(org)) * longint'(inv);
        if (f < 0)
            f = 0;
        if (f > (longint'(used - 1) <<< Q_SHIFT))
            f = longint'(used - 1) <<< Q_SHIFT;
        b = f >>> Q_SHIFT;
        if (b > used - 2)
            b = used - 2;
        return int'(b);
    endfunction

    // coordinate mostly inside the grid span, with margins that reach the clamps
    function automatic logic signed [COORD_W-1:0] make_coord(
        input logic signed [COORD_W-1:0] org, input logic signed [COORD_W-1:0] inv,
        input logic [USED_W-1:0] used_raw);
        longint span;
        longint mag;
        longint off;
        if (inv == 0 || $urandom_range(0, 9) == 0)
            return $urandom;
        mag  = (inv < 0) ? -longint'(inv) : longint'(inv);
        span = (longint'(used_cells(used_raw, DEF_MAX_COLUMNS) - 1) <<< Q_SHIFT) / mag;
        if (span > (longint'(1) <<< 30))
            span = longint'(1) <<< 30;
        off = longint'($urandom_range(0, 32'(span + span / 2 + 2))) - span / 4 - 1;
        if (inv < 0)
            off = -off;
        return COORD_W'(longint'(org) + off);
    endfunction

    function automatic logic signed [ELEV_W-1:0] rand_elevation();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return ELEV_W'(25'h1000000);
        if (pick < 20)
            return ELEV_W'(25'h0FFFFFF);
        if (pick < 45)
            return ELEV_W'($urandom);
        return ELEV_W'($urandom_range(0, 200000)) - ELEV_W'(100000);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_spacing();
        longint mag;
        mag = (longint'(1) <<< $urandom_range(16, 27)) + $urandom_range(0, 4095);
        return COORD_W'(($urandom_range(0, 1) == 1) ? -mag : mag);
    endfunction

    function automatic logic [USED_W-1:0] rand_used();
        if ($urandom_range(0, 5) == 0)
            return USED_W'($urandom_range(100, 512));
        return USED_W'($urandom_range(2, 20));
    endfunction

    function automatic int sender_gap();
        int pick;
        if (tx_steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int receiver_hold();
        int pick;
        if (rx_steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic m, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic [CELL_W-1:0] r, input logic [CELL_W-1:0] c,
                             input logic signed [ELEV_W-1:0] e);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid     <= 1'b1;
        mode           <= m;
        query_x        <= x;
        query_y        <= y;
        cell_row       <= r;
        cell_col       <= c;
        cell_elevation <= e;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_cell(input int r, input int c, input logic signed [ELEV_W-1:0] e);
        send_item(MODE_WRITE, $urandom, $urandom, CELL_W'(r), CELL_W'(c), e);
        cell_written[r * DEF_MAX_COLUMNS + c] = 1'b1;
    endtask

    // fills any unwritten neighbor first, then sends the query
    task automatic query_at(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
        int r0;
        int c0;
        int dr;
        int dc;
        r0 = cell_base(y, org_y, inv_y, rows_used);
        c0 = cell_base(x, org_x, inv_x, cols_used);
        for (dr = 0; dr < 2; dr++)
            for (dc = 0; dc < 2; dc++)
                if (!cell_written[(r0 + dr) * DEF_MAX_COLUMNS + c0 + dc])
                    write_cell(r0 + dr, c0 + dc, rand_elevation());
        send_item(MODE_QUERY, x, y, CELL_W'($urandom), CELL_W'($urandom), ELEV_W'($urandom));
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic write_config(input logic signed [COORD_W-1:0] ox,
                                input logic signed [COORD_W-1:0] oy,
                                input logic signed [COORD_W-1:0] ix,
                                input logic signed [COORD_W-1:0] iy,
                                input logic [USED_W-1:0] nc, input logic [USED_W-1:0] nr);
        org_x     = ox;
        org_y     = oy;
        inv_x     = ix;
        inv_y     = iy;
        cols_used = nc;
        rows_used = nr;
        put_reg(CFG_ORIGIN_X, ox);
        put_reg(CFG_ORIGIN_Y, oy);
        put_reg(CFG_INV_SPACING_X, ix);
        put_reg(CFG_INV_SPACING_Y, iy);
        put_reg(CFG_COLUMNS_USED, CFG_W'(nc));
        put_reg(CFG_ROWS_USED, CFG_W'(nr));
        cfg_write <= 1'b0;
    endtask

    // block idle: all results back and the pipeline drained of writes
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_phase(input int p);
        case (p)
            0: write_config(32'sh80000000, 32'sh7FFFFFFF, 32'sd8388608, -32'sd4194304,
                            USED_W'(0), USED_W'(1));
            1: write_config($urandom, $urandom, 32'sd1048576, 32'sd4194304,
                            USED_W'(512), USED_W'(2));
            2: write_config($urandom, $urandom, -32'sd2097152, 32'sd1048576,
                            USED_W'(2), USED_W'(512));
            3: write_config(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                            USED_W'(1023), USED_W'(513));
            4: write_config($urandom, $urandom, 32'sd0, 32'sd4194304, USED_W'(5), USED_W'(7));
            default: write_config($urandom, $urandom, rand_spacing(), rand_spacing(),
                                  rand_used(), rand_used());
        endcase
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int n;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                n = HOLD_CYCLES;
                hold_off = 1'b0;
            end
            else
            begin
                n = receiver_hold();
            end
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        int start;
        int pick;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        item_valid     = 1'b0;
        mode           = MODE_WRITE;
        query_x        = '0;
        query_y        = '0;
        cell_row       = '0;
        cell_col       = '0;
        cell_elevation = '0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        hold_off       = 1'b0;
        items_sent     = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero spacing, every query lands on the first cell
        write_cell(0, 0, ELEV_W'(25'h0FFFFFF));
        write_cell(0, 1, ELEV_W'(25'h1000000));
        write_cell(1, 0, ELEV_W'(25'h1000000));
        write_cell(1, 1, ELEV_W'(25'h0FFFFFF));
        write_cell(511, 511, ELEV_W'(25'h1000000));
        write_cell(511, 0, ELEV_W'(25'h0FFFFFF));
        query_at(32'sd0, 32'sd0);
        query_at(32'sh80000000, 32'sh7FFFFFFF);
        query_at(32'sh7FFFFFFF, 32'sh80000000);

        // half a cell per unit: midpoints give rounding ties, far edge has weight one
        settle();
        write_config(32'sd0, 32'sd0, 32'sd8388608, 32'sd8388608, USED_W'(2), USED_W'(2));
        query_at(32'sd0, 32'sd0);
        query_at(32'sd1, 32'sd0);
        query_at(32'sd2, 32'sd0);
        query_at(32'sd3, 32'sd0);
        query_at(-32'sd1, 32'sd0);
        query_at(32'sd1, 32'sd1);
        query_at(32'sd2, 32'sd2);
        query_at(32'sd0, 32'sd1);
        query_at(32'sd1, 32'sd2);

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            set_phase(p);
            if (p == HOLD_PHASE)
            begin
                tx_steady = 1'b1;
                hold_off  = 1'b1;
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    write_cell($urandom_range(0, DEF_MAX_ROWS - 1),
                               $urandom_range(0, DEF_MAX_COLUMNS - 1), rand_elevation());
                else if (pick == 1)
                    query_at($urandom, $urandom);
                else
                    query_at(make_coord(org_x, inv_x, cols_used),
                             make_coord(org_y, inv_y, rows_used));
            end
        end

        settle();
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/gbe_pkg.sv
hw/rtl/grid_bilinear_elevation_unit.sv
hw/rtl/gbe_checker.sv
test/grid_elevation_checker.sv
test/tb_grid_bilinear_elevation_unit.sv
